// ----- rtl/biq_pkg.sv -----
// shared constants, codes, types and the rounding function of the biquad filter
// no dependencies; every other file imports this package
package biq_pkg;

	localparam int MAX_SECTIONS = 4;
	localparam int COEF_DEPTH   = 1 + 4 * MAX_SECTIONS;
	localparam int DELAY_DEPTH  = 2 * MAX_SECTIONS;
	localparam int COEF_AW      = $clog2(COEF_DEPTH);
	localparam int DLY_AW       = $clog2(DELAY_DEPTH);
	localparam int SEC_W        = $clog2(MAX_SECTIONS + 1);
	localparam int SEC_IW       = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
	localparam int CFG_W        = 3;
	localparam int ACC_W        = 34;

	// request function codes
	localparam logic [1:0] FUNC_FILTER = 2'd0;
	localparam logic [1:0] FUNC_COEF   = 2'd1;
	localparam logic [1:0] FUNC_CLEAR  = 2'd2;

	// accumulator operations
	localparam logic [2:0] OP_LOAD  = 3'd0; // acc = gain * x
	localparam logic [2:0] OP_SUB   = 3'd1; // acc -= a * w
	localparam logic [2:0] OP_SUB_Y = 3'd2; // acc = rnd(acc) << 14 - a1 * w1
	localparam logic [2:0] OP_ADD_W = 3'd3; // w = rnd(acc); acc = w << 14 + b1 * w1
	localparam logic [2:0] OP_ADD   = 3'd4; // acc += b2 * w2
	localparam logic [2:0] OP_FIN   = 3'd5; // y = rnd(acc)

	typedef logic [2:0] op_t;

	typedef struct packed {
		logic               vld;
		op_t                op;
		logic [COEF_AW-1:0] coef_addr;
		logic [DLY_AW-1:0]  dly_addr;
	} iss_t;

	typedef struct packed {
		logic                     we;
		logic [DLY_AW-1:0]        addr;
		logic signed [15:0]       data;
	} dwr_t;

	typedef struct packed {
		logic               fin;
		logic signed [15:0] y;
		logic               sat;
	} res_t;

	typedef struct packed {
		logic signed [15:0] val;
		logic               sat;
	} rnd_t;

	localparam logic [ACC_W:0] RND_HALF = (ACC_W + 1)'(1 << 13);
	localparam logic signed [ACC_W-14:0] SAT_HI = (ACC_W - 13)'(32767);
	localparam logic signed [ACC_W-14:0] SAT_LO = -(ACC_W - 13)'(32768);

	// round half up from q.29 to q1.15 and saturate
	function automatic rnd_t round_sat(input logic signed [ACC_W-1:0] a);
		logic [ACC_W:0]            s;
		logic signed [ACC_W-14:0]  r;
		rnd_t                      o;
		s = {a[ACC_W-1], a} + RND_HALF;
		r = s[ACC_W:14];
		if (r > SAT_HI) begin
			o.val = 16'sh7fff;
			o.sat = 1'b1;
		end else if (r < SAT_LO) begin
			o.val = 16'sh8000;
			o.sat = 1'b1;
		end else begin
			o.val = r[15:0];
			o.sat = 1'b0;
		end
		return o;
	endfunction

	// q1.15 word placed at q.29 scale
	function automatic logic signed [ACC_W-1:0] q29(input logic signed [15:0] v);
		return {{(ACC_W - 30){v[15]}}, v, 14'b0};
	endfunction

endpackage

// ----- rtl/biq_if.sv -----
// channel interfaces of the biquad filter: requests, results, configuration
// depends on biq_pkg
interface biq_req_if import biq_pkg::*;;
	logic               valid;
	logic               ready;
	logic [1:0]         func;
	logic [4:0]         coef_index;
	logic signed [15:0] value;

	modport source (output valid, func, coef_index, value, input ready);
	modport sink (input valid, func, coef_index, value, output ready);
endinterface

interface biq_res_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] sample_out;
	logic               saturated;

	modport source (output valid, sample_out, saturated, input ready);
	modport sink (input valid, sample_out, saturated, output ready);
endinterface

interface biq_cfg_if import biq_pkg::*;;
	logic             valid;
	logic             ready;
	logic [CFG_W-1:0] section_count;

	modport source (output valid, section_count, input ready);
	modport sink (input valid, section_count, output ready);
endinterface

// ----- rtl/cascaded_biquad_iir_filter.sv -----
// filter sample: a gain step, the steps of each active section and a final step; ready again with the result
// one step per cycle through the shared 16x16 multiplier while the pipeline is not frozen
// coefficient write, state clear, unused function: the block stays ready
// result register lets the next request in while a result waits; the pipeline stalls only at the final step
// reset: section count 1, coefficients and delay words read as zero, no result pending
// depends on biq_pkg, biq_if, biq_seq, biq_store, biq_mac
module cascaded_biquad_iir_filter import biq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	biq_req_if.sink   request,
	biq_res_if.source result,
	biq_cfg_if.sink   cfg
);

	// configuration register
	logic [CFG_W-1:0]   section_count_q;
	logic [SEC_W-1:0]   n_sec;

	// request side
	logic               req_acc;
	logic               start;
	logic               coef_we;
	logic               dly_clr;
	logic signed [15:0] x_q;

	// pipeline plumbing
	iss_t               iss;
	dwr_t               dwr;
	res_t               res;
	logic               seq_active;
	logic               mac_busy;
	logic               adv;
	logic signed [15:0] coef_rd;
	logic signed [15:0] dly_rd;

	// result register
	logic               out_valid_q;
	logic signed [15:0] out_y_q;
	logic               out_sat_q;

	// configuration is always taken; the user must write it only while idle, the block does not enforce this
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			section_count_q <= CFG_W'(1);
		end else if (cfg.valid) begin
			section_count_q <= cfg.section_count;
		end
	end

	// counts above the section budget run the full cascade
	assign n_sec = (32'(section_count_q) > MAX_SECTIONS) ? SEC_W'(MAX_SECTIONS)
	                                                      : SEC_W'(section_count_q);

	// one request at a time; nothing in flight means ready
	assign request.ready = !seq_active && !mac_busy;
	assign req_acc       = request.valid && request.ready;
	assign start         = req_acc && (request.func == FUNC_FILTER);
	assign coef_we       = req_acc && (request.func == FUNC_COEF)
	                       && (32'(request.coef_index) < COEF_DEPTH);
	assign dly_clr       = req_acc && (request.func == FUNC_CLEAR);

	// sample held for the gain step
	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= request.value;
		end
	end

	// the whole pipeline freezes only while the final step waits on a full result register
	assign adv = !(res.fin && out_valid_q && !result.ready);

	biq_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.n      (n_sec),
		.adv    (adv),
		.iss    (iss),
		.active (seq_active)
	);

	biq_store u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.coef_we    (coef_we),
		.coef_waddr (COEF_AW'(request.coef_index)),
		.coef_wdata (request.value),
		.dly_clr    (dly_clr),
		.dwr        (dwr),
		.ren        (adv),
		.iss        (iss),
		.coef_rd    (coef_rd),
		.dly_rd     (dly_rd)
	);

	biq_mac u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.iss     (iss),
		.x       (x_q),
		.coef_rd (coef_rd),
		.dly_rd  (dly_rd),
		.dwr     (dwr),
		.res     (res),
		.busy    (mac_busy)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.fin && adv) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.fin && adv) begin
			out_y_q   <= res.y;
			out_sat_q <= res.sat;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.sample_out = out_y_q;
	assign result.saturated  = out_sat_q;

endmodule

// ----- rtl/biq_seq.sv -----
// operation sequencer: issues one multiply-accumulate step per cycle for a sample while adv is high
// depends on biq_pkg
module biq_seq import biq_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [SEC_W-1:0] n,
	input  logic             adv,
	output iss_t             iss,
	output logic             active
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_GAIN = 2'd1;
	localparam logic [1:0] ST_SEC  = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	logic [1:0]        state_q, state_d;
	logic [SEC_IW-1:0] sec_q, sec_d;
	logic [1:0]        k_q, k_d;
	logic              last_sec;

	assign last_sec = (SEC_W'(sec_q) + SEC_W'(1)) == n;
	assign active   = state_q != ST_IDLE;

	always_comb begin
		state_d       = state_q;
		sec_d         = sec_q;
		k_d           = k_q;
		iss.vld       = 1'b0;
		iss.op        = OP_LOAD;
		iss.coef_addr = COEF_AW'({sec_q, k_q}) + COEF_AW'(1);
		iss.dly_addr  = DLY_AW'({sec_q, k_q[0]});
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_GAIN;
				end
			end
			ST_GAIN: begin
				iss.vld       = 1'b1;
				iss.op        = OP_LOAD;
				iss.coef_addr = '0;
				sec_d         = '0;
				k_d           = '0;
				state_d       = (n == '0) ? ST_FIN : ST_SEC;
			end
			ST_SEC: begin
				iss.vld = 1'b1;
				case (k_q)
					2'd0:    iss.op = (sec_q == '0) ? OP_SUB : OP_SUB_Y;
					2'd1:    iss.op = OP_SUB;
					2'd2:    iss.op = OP_ADD_W;
					default: iss.op = OP_ADD;
				endcase
				k_d = k_q + 2'd1;
				if (k_q == 2'd3) begin
					if (last_sec) begin
						state_d = ST_FIN;
					end else begin
						sec_d = sec_q + SEC_IW'(1);
					end
				end
			end
			ST_FIN: begin
				iss.vld = 1'b1;
				iss.op  = OP_FIN;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sec_q   <= '0;
			k_q     <= '0;
		end else if (adv) begin
			state_q <= state_d;
			sec_q   <= sec_d;
			k_q     <= k_d;
		end
	end

endmodule

// ----- rtl/biq_store.sv -----
// coefficient and delay memories with registered reads and per-entry valid bits
// depends on biq_pkg
module biq_store import biq_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               coef_we,
	input  logic [COEF_AW-1:0] coef_waddr,
	input  logic signed [15:0] coef_wdata,
	input  logic               dly_clr,
	input  dwr_t               dwr,
	input  logic               ren,
	input  iss_t               iss,
	output logic signed [15:0] coef_rd,
	output logic signed [15:0] dly_rd
);

	logic signed [15:0]     coef_mem [COEF_DEPTH];
	logic signed [15:0]     dly_mem [DELAY_DEPTH];
	logic [COEF_DEPTH-1:0]  coef_vld_q;
	logic [DELAY_DEPTH-1:0] dly_vld_q;
	logic signed [15:0]     coef_rd_q, dly_rd_q;
	logic                   coef_rv_q, dly_rv_q;

	always_ff @(posedge clk) begin
		if (coef_we) begin
			coef_mem[coef_waddr] <= coef_wdata;
		end
		if (dwr.we) begin
			dly_mem[dwr.addr] <= dwr.data;
		end
		if (ren) begin
			coef_rd_q <= coef_mem[iss.coef_addr];
			dly_rd_q  <= dly_mem[iss.dly_addr];
		end
	end

	// never-written entries, and delay entries not written since the last clear, read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_vld_q <= '0;
			dly_vld_q  <= '0;
			coef_rv_q  <= 1'b0;
			dly_rv_q   <= 1'b0;
		end else begin
			if (coef_we) begin
				coef_vld_q[coef_waddr] <= 1'b1;
			end
			if (dly_clr) begin
				dly_vld_q <= '0;
			end else if (dwr.we) begin
				dly_vld_q[dwr.addr] <= 1'b1;
			end
			if (ren) begin
				coef_rv_q <= coef_vld_q[iss.coef_addr];
				dly_rv_q  <= dly_vld_q[iss.dly_addr];
			end
		end
	end

	assign coef_rd = coef_rv_q ? coef_rd_q : '0;
	assign dly_rd  = dly_rv_q ? dly_rd_q : '0;

endmodule

// ----- rtl/biq_mac.sv -----
// shared multiplier, accumulator, rounding/saturation and delay write-back
// depends on biq_pkg
module biq_mac import biq_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  iss_t               iss,
	input  logic signed [15:0] x,
	input  logic signed [15:0] coef_rd,
	input  logic signed [15:0] dly_rd,
	output dwr_t               dwr,
	output res_t               res,
	output logic               busy
);

	logic                     vld_s1, vld_s2;
	op_t                      op_s1, op_s2;
	logic [DLY_AW-1:0]        daddr_s1, daddr_s2;
	logic signed [15:0]       opnd_s2;
	logic signed [31:0]       prod_s2;
	logic signed [15:0]       opnd;
	logic signed [31:0]       prod;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  prod_x;
	logic signed [15:0]       w_q;
	logic                     sat_q;
	rnd_t                     rnd;

	assign opnd   = (op_s1 == OP_LOAD) ? x : dly_rd;
	assign prod   = coef_rd * opnd;
	assign prod_x = ACC_W'(prod_s2);
	assign rnd    = round_sat(acc_q);
	assign busy   = vld_s1 || vld_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			op_s1  <= OP_LOAD;
			op_s2  <= OP_LOAD;
		end else if (adv) begin
			vld_s1 <= iss.vld;
			vld_s2 <= vld_s1;
			op_s1  <= iss.op;
			op_s2  <= op_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			daddr_s1 <= iss.dly_addr;
			daddr_s2 <= daddr_s1;
			opnd_s2  <= dly_rd;
			prod_s2  <= prod;
			if (vld_s2) begin
				case (op_s2)
					OP_LOAD: begin
						acc_q <= prod_x;
						sat_q <= 1'b0;
					end
					OP_SUB: begin
						acc_q <= acc_q - prod_x;
					end
					OP_SUB_Y: begin
						acc_q <= q29(rnd.val) - prod_x;
						sat_q <= sat_q | rnd.sat;
					end
					OP_ADD_W: begin
						acc_q <= q29(rnd.val) + prod_x;
						sat_q <= sat_q | rnd.sat;
						w_q   <= rnd.val;
					end
					OP_ADD: begin
						acc_q <= acc_q + prod_x;
					end
					default: begin
						acc_q <= acc_q;
					end
				endcase
			end
		end
	end

	// w2 <- old w1 when w is formed, w1 <- w in the following cycle
	always_comb begin
		dwr.we   = 1'b0;
		dwr.addr = {daddr_s2[DLY_AW-1:1], 1'b1};
		dwr.data = opnd_s2;
		if (vld_s2 && adv) begin
			case (op_s2)
				OP_ADD_W: begin
					dwr.we = 1'b1;
				end
				OP_ADD: begin
					dwr.we   = 1'b1;
					dwr.addr = {daddr_s2[DLY_AW-1:1], 1'b0};
					dwr.data = w_q;
				end
				default: begin
					dwr.we = 1'b0;
				end
			endcase
		end
	end

	assign res.fin = vld_s2 && (op_s2 == OP_FIN);
	assign res.y   = rnd.val;
	assign res.sat = sat_q | rnd.sat;

endmodule

// ----- rtl/biq_checker.sv -----
// port-level checks on the biquad filter, bound to the top level
// depends on biq_pkg and cascaded_biquad_iir_filter
module biq_assert_checker import biq_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_ready,
	input logic [1:0]         req_func,
	input logic               res_valid,
	input logic               res_ready,
	input logic signed [15:0] res_sample_out,
	input logic               res_saturated
);

	// a waiting result holds its value
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_sample_out)
		&& $stable(res_saturated))
	else $error("result changed while stalled");

	// a sample request keeps the block busy the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req_func == FUNC_FILTER) |=> !req_ready)
	else $error("ready after a sample request");

	// coefficient writes, clears and unused codes leave the block ready
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req_func != FUNC_FILTER) |=> req_ready)
	else $error("not ready after a single-cycle request");

	// a new result only appears while a sample is in work
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(!req_ready))
	else $error("result without a sample in work");

endmodule

bind cascaded_biquad_iir_filter biq_assert_checker u_biq_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (request.valid),
	.req_ready      (request.ready),
	.req_func       (request.func),
	.res_valid      (result.valid),
	.res_ready      (result.ready),
	.res_sample_out (result.sample_out),
	.res_saturated  (result.saturated)
);

// ----- dv/biq_checker.sv -----
`timescale 1ns / 100ps
// checker of the biquad filter: watches request, result and configuration channels
// keeps its own fixed-point copy of the cascade and compares each result in order
// depends on biq_pkg
module biq_checker import biq_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  logic               req_ready,
	input  logic [1:0]         req_func,
	input  logic [4:0]         req_coef_index,
	input  logic signed [15:0] req_value,
	input  logic               res_valid,
	input  logic               res_ready,
	input  logic signed [15:0] res_sample,
	input  logic               res_saturated,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [CFG_W-1:0]   cfg_sections,
	output int                 mismatches,
	output int                 outstanding,
	output int                 results_checked
);

	localparam int GAIN_SLOT = 0;

	typedef struct packed {
		logic signed [15:0] sample;
		logic               clipped;
	} q15_t;

	logic signed [15:0] coef_table [COEF_DEPTH];
	logic signed [15:0] delay_line [DELAY_DEPTH];
	logic [CFG_W-1:0]   section_sel;
	q15_t               predicted_samples [$];
	int                 fail_tally;

	// q.29 to q1.15, round half up, clip to 16 bits
	function automatic q15_t round_to_q15(input longint acc);
		longint r;
		q15_t   o;
		r = (acc + 64'sd8192) >>> 14;
		if (r > 64'sd32767) begin
			o.sample  = 16'sh7fff;
			o.clipped = 1'b1;
		end else if (r < -64'sd32768) begin
			o.sample  = 16'sh8000;
			o.clipped = 1'b1;
		end else begin
			o.sample  = r[15:0];
			o.clipped = 1'b0;
		end
		return o;
	endfunction

	// gain, then each active section in turn; updates the delay line
	function automatic q15_t run_cascade(input logic signed [15:0] x);
		int                 n;
		longint             acc;
		longint             yacc;
		logic signed [15:0] y;
		logic signed [15:0] w;
		logic signed [15:0] w1;
		logic signed [15:0] w2;
		q15_t               step;
		q15_t               o;
		n = (int'(section_sel) > MAX_SECTIONS) ? MAX_SECTIONS : int'(section_sel);
		o.clipped = 1'b0;
		y = '0;
		acc = longint'(coef_table[GAIN_SLOT]) * longint'(x);
		if (n == 0) begin
			step = round_to_q15(acc);
			y = step.sample;
			o.clipped = step.clipped;
		end
		for (int s = 0; s < n; s++) begin
			w1 = delay_line[2 * s];
			w2 = delay_line[2 * s + 1];
			if (s > 0)
				acc = longint'(y) * 64'sd16384;
			acc -= longint'(coef_table[1 + 4 * s]) * longint'(w1);
			acc -= longint'(coef_table[2 + 4 * s]) * longint'(w2);
			step = round_to_q15(acc);
			w = step.sample;
			o.clipped |= step.clipped;
			yacc = longint'(w) * 64'sd16384
				+ longint'(coef_table[3 + 4 * s]) * longint'(w1)
				+ longint'(coef_table[4 + 4 * s]) * longint'(w2);
			step = round_to_q15(yacc);
			y = step.sample;
			o.clipped |= step.clipped;
			delay_line[2 * s + 1] = w1;
			delay_line[2 * s]     = w;
		end
		o.sample = y;
		return o;
	endfunction

	task automatic log_failure(input string what);
		if (fail_tally < 10)
			$display("ERROR at %0t: %s", $time, what);
		fail_tally++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		q15_t want;
		if (!arst_n) begin
			foreach (coef_table[i])
				coef_table[i] = '0;
			foreach (delay_line[i])
				delay_line[i] = '0;
			section_sel = 3'd1;
			predicted_samples.delete();
			fail_tally = 0;
			mismatches <= 0;
			outstanding <= 0;
			results_checked <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				section_sel = cfg_sections;
			if (res_valid && res_ready) begin
				if (predicted_samples.size() == 0) begin
					log_failure($sformatf("result %0d sat %0b with no request pending",
						res_sample, res_saturated));
				end else begin
					want = predicted_samples.pop_front();
					if (res_sample !== want.sample || res_saturated !== want.clipped)
						log_failure($sformatf("expected %0d sat %0b, got %0d sat %0b",
							want.sample, want.clipped, res_sample, res_saturated));
				end
				results_checked <= results_checked + 1;
			end
			if (req_valid && req_ready) begin
				case (req_func)
					FUNC_FILTER: predicted_samples.push_back(run_cascade(req_value));
					FUNC_COEF: begin
						if (req_coef_index < COEF_DEPTH)
							coef_table[req_coef_index] = req_value;
					end
					FUNC_CLEAR: begin
						foreach (delay_line[i])
							delay_line[i] = '0;
					end
					default: ;
				endcase
			end
			mismatches <= fail_tally;
			outstanding <= predicted_samples.size();
		end
	end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// top of the biquad filter testbench: clock, reset, request and config stimulus, result back-pressure, verdict
// depends on biq_pkg, biq_if, the filter rtl and biq_checker
module tb_top import biq_pkg::*; ;

	// unused function code, the block must swallow it without a result
	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam logic [4:0] GAIN_SLOT = 5'd0;
	// settle time after the last result so trailing work can finish
	localparam int SETTLE_CYCLES = 32;
	localparam int LONG_STALL_CYCLES = 400;
	localparam int PHASES = 12;
	localparam int ITEMS_PER_PHASE = 86;

	logic clk;
	logic arst_n;

	biq_req_if req_ch ();
	biq_res_if res_ch ();
	biq_cfg_if cfg_ch ();

	int mismatches;
	int outstanding;
	int results_checked;

	// handshake idle odds in percent, changed per phase
	int sender_idle_pct;
	int recv_idle_pct;
	bit long_stall_armed;

	int requests_sent;
	int samples_sent;

	// section count per random phase, extremes and clamped values included
	int section_plan [PHASES] = '{1, 2, 3, 4, 0, 7, 4, 5, 6, 3, 2, 4};
	// magnitude limits that keep a1, a2, b1, b2 in a mostly stable region
	int tame_span [4] = '{12000, 6000, 16384, 16384};

	cascaded_biquad_iir_filter dut (
		.clk    (clk),
		.arst_n (arst_n),
		.request(req_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	biq_checker chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_ch.valid),
		.req_ready      (req_ch.ready),
		.req_func       (req_ch.func),
		.req_coef_index (req_ch.coef_index),
		.req_value      (req_ch.value),
		.res_valid      (res_ch.valid),
		.res_ready      (res_ch.ready),
		.res_sample     (res_ch.sample_out),
		.res_saturated  (res_ch.saturated),
		.cfg_valid      (cfg_ch.valid),
		.cfg_ready      (cfg_ch.ready),
		.cfg_sections   (cfg_ch.section_count),
		.mismatches     (mismatches),
		.outstanding    (outstanding),
		.results_checked(results_checked)
	);

	// 10 ns clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard limit on run length, far above the slowest legal run
	initial begin
		#5_000_000;
		$display("Test completed with failures");
		$finish;
	end

	// result side: random back-pressure, plus one long hold-off when armed
	initial begin
		int stall_left;
		bit stall_taken;
		stall_left = 0;
		stall_taken = 1'b0;
		res_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				res_ch.ready <= 1'b0;
				stall_left--;
			end else if (long_stall_armed && !stall_taken) begin
				// hold results back long enough for the input side to fill and stall
				stall_taken = 1'b1;
				stall_left = LONG_STALL_CYCLES - 1;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// signed value uniform in [-m, m]
	function automatic logic signed [15:0] rand_span(input int m);
		return 16'(int'($urandom_range(2 * m)) - m);
	endfunction

	// one request; each cycle may idle first, returns on the edge where it was accepted
	task automatic send_request(input logic [1:0] f, input logic [4:0] idx,
		input logic signed [15:0] v);
		while ($urandom_range(99) < sender_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.func <= f;
		req_ch.coef_index <= idx;
		req_ch.value <= v;
		do @(posedge clk); while (!req_ch.ready);
		requests_sent++;
		if (f == FUNC_FILTER)
			samples_sent++;
	endtask

	task automatic send_sample(input logic signed [15:0] v);
		send_request(FUNC_FILTER, 5'($urandom), v);
	endtask

	// stop offering, wait for every predicted sample, then let trailing work finish
	task automatic wait_all_results();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// section count is only changed with the block idle
	task automatic write_sections(input logic [CFG_W-1:0] n);
		wait_all_results();
		cfg_ch.valid <= 1'b1;
		cfg_ch.section_count <= n;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
	endtask

	// full coefficient set: gain plus a1, a2, b1, b2 of every section
	task automatic load_coefficients(input bit tame);
		send_request(FUNC_COEF, GAIN_SLOT, tame ? rand_span(16000) : 16'($urandom));
		for (int s = 0; s < MAX_SECTIONS; s++)
			for (int k = 0; k < 4; k++)
				send_request(FUNC_COEF, 5'(1 + 4 * s + k),
					tame ? rand_span(tame_span[k]) : 16'($urandom));
	endtask

	initial begin
		int pick;
		int mode;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.func = FUNC_FILTER;
		req_ch.coef_index = '0;
		req_ch.value = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.section_count = '0;
		sender_idle_pct = 0;
		recv_idle_pct = 0;
		long_stall_armed = 1'b0;
		requests_sent = 0;
		samples_sent = 0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes of coefficients and samples, all function codes
		write_sections(3'd4);
		send_request(FUNC_COEF, GAIN_SLOT, 16'sh4000);
		send_request(FUNC_COEF, 5'd1, 16'sh8000);
		send_request(FUNC_COEF, 5'd4, 16'sh7fff);
		send_request(FUNC_COEF, 5'd16, 16'sh2000);
		// slots past the table must be dropped
		send_request(FUNC_COEF, 5'd17, 16'sd1234);
		send_request(FUNC_COEF, 5'd31, -16'sd1);
		send_sample(16'sh7fff);
		send_sample(16'sh8000);
		send_sample(16'sd0);
		send_sample(16'sd1);
		// unused function code, no result
		send_request(FUNC_UNUSED, 5'd31, -16'sd1);
		send_sample(-16'sd1);
		// clear drops delay words, coefficients stay
		send_request(FUNC_CLEAR, 5'd0, 16'sd0);
		send_sample(16'sh7fff);
		// gain of -2 on full-scale negative input clips
		send_request(FUNC_COEF, GAIN_SLOT, 16'sh8000);
		send_sample(16'sh8000);
		send_sample(16'sh7fff);
		// gain-only path with zero sections
		write_sections(3'd0);
		send_sample(16'sh8000);
		send_sample(16'sd12345);
		// count above the section limit gets clamped
		write_sections(3'd7);
		send_sample(16'sd100);
		send_sample(-16'sd200);

		// random phases: fresh coefficient set, clear, then mostly samples
		for (int p = 0; p < PHASES; p++) begin
			mode = p / 4;
			sender_idle_pct = (mode == 0) ? 29 : (mode == 1) ? 45 : 0;
			recv_idle_pct   = (mode == 0) ? 45 : (mode == 1) ? 29 : 0;
			write_sections(3'(section_plan[p]));
			load_coefficients($urandom_range(99) < 70);
			send_request(FUNC_CLEAR, 5'($urandom), 16'($urandom));
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				// long result hold-off while samples keep coming
				if (p == 1 && i == 60)
					long_stall_armed = 1'b1;
				// sender pause until the pipe has fully drained
				if (p == 6 && i == 70)
					wait_all_results();
				pick = $urandom_range(99);
				if (pick < 80) begin
					if ($urandom_range(1))
						send_sample(16'($urandom));
					else
						send_sample(rand_span(4000));
				end else if (pick < 88) begin
					// stray coefficient write, any slot in or out of range
					send_request(FUNC_COEF, 5'($urandom_range(31)), 16'($urandom));
				end else if (pick < 93) begin
					send_request(FUNC_CLEAR, 5'($urandom), 16'($urandom));
				end else if (pick < 97) begin
					send_request(FUNC_UNUSED, 5'($urandom), 16'($urandom));
				end else begin
					load_coefficients($urandom_range(99) < 70);
					send_request(FUNC_CLEAR, 5'($urandom), 16'($urandom));
				end
			end
		end

		wait_all_results();
		$display("covered %0d requests (%0d samples), section counts 0 to 7, three idle mixes",
			requests_sent, samples_sent);
		$display("%0d filtered samples compared, %0d mismatches", results_checked, mismatches);
		if (mismatches == 0 && outstanding == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
